>>> rtl/uqpd_pkg.sv
// ----------------------------------------------------------------------------
// uqpd_pkg
// Types, character codes and the hex nibble table for the query decoder.
// ----------------------------------------------------------------------------
package uqpd_pkg;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_END  = 1'b1;

    localparam logic [1:0] KIND_KEY   = 2'd0;
    localparam logic [1:0] KIND_VALUE = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] DIGIT_MASK = 8'h1F;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_HIGH = 3'b010,
        PH_LOW  = 3'b100
    } phase_t;

    typedef struct packed {
        logic       query_done;
        logic       pair_kept;
        logic [1:0] kind;
        logic [7:0] out_byte;
    } result_t;

    // low five bits of a hex digit -> nibble; non-hex codes map as they fall
    function automatic logic [3:0] nibble_of(input logic [4:0] idx);
        logic [3:0] nib;
        case (idx)
            5'd1:    nib = 4'd10;
            5'd2:    nib = 4'd11;
            5'd3:    nib = 4'd12;
            5'd4:    nib = 4'd13;
            5'd5:    nib = 4'd14;
            5'd6:    nib = 4'd15;
            5'd17:   nib = 4'd1;
            5'd18:   nib = 4'd2;
            5'd19:   nib = 4'd3;
            5'd20:   nib = 4'd4;
            5'd21:   nib = 4'd5;
            5'd22:   nib = 4'd6;
            5'd23:   nib = 4'd7;
            5'd24:   nib = 4'd8;
            5'd25:   nib = 4'd9;
            default: nib = 4'd0;
        endcase
        return nib;
    endfunction

endpackage

>>> rtl/uqpd_step.sv
// ----------------------------------------------------------------------------
// uqpd_step
// Parser state and per-byte decode: escape tracking, key/value split and
// pair-end markers. One accepted byte updates state and yields 0 or 1 result.
// ----------------------------------------------------------------------------
module uqpd_step
    import uqpd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic       opcode,
    input  logic [7:0] in_byte,
    output logic       res_valid,
    output result_t    res
);

    phase_t     phase_reg, phase_next;
    logic [3:0] high_reg, high_next;
    logic       in_key_reg, in_key_next;
    logic       key_seen_reg, key_seen_next;

    logic       emit;
    logic [7:0] emit_byte;
    logic [3:0] nib;

    logic [7:0] digit_bits;
    assign digit_bits = in_byte & DIGIT_MASK;
    assign nib = nibble_of(digit_bits[4:0]);

    always_comb
    begin
        phase_next    = phase_reg;
        high_next     = high_reg;
        in_key_next   = in_key_reg;
        key_seen_next = key_seen_reg;
        res_valid     = 1'b0;
        res           = '0;
        emit          = 1'b0;
        emit_byte     = in_byte;
        if (accept)
        begin
            if (opcode == OP_END)
            begin
                res_valid      = 1'b1;
                res.kind       = KIND_END;
                res.pair_kept  = key_seen_reg;
                res.query_done = 1'b1;
                phase_next     = PH_IDLE;
                high_next      = 4'd0;
                in_key_next    = 1'b1;
                key_seen_next  = 1'b0;
            end
            else
            begin
                case (phase_reg)
                    PH_HIGH:
                    begin
                        high_next  = nib;
                        phase_next = PH_LOW;
                    end
                    PH_LOW:
                    begin
                        phase_next = PH_IDLE;
                        emit       = 1'b1;
                        emit_byte  = {high_reg, nib};
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                        if (in_byte == CH_PERCENT)
                        begin
                            phase_next = PH_HIGH;
                        end
                        else if (in_byte == CH_AMP)
                        begin
                            res_valid     = 1'b1;
                            res.kind      = KIND_END;
                            res.pair_kept = key_seen_reg;
                            key_seen_next = 1'b0;
                            in_key_next   = 1'b1;
                        end
                        else if (in_key_reg && in_byte == CH_EQUAL)
                        begin
                            in_key_next = 1'b0;
                        end
                        else
                        begin
                            emit = 1'b1;
                        end
                    end
                endcase
            end
            if (emit)
            begin
                res_valid    = 1'b1;
                res.out_byte = emit_byte;
                res.kind     = in_key_reg ? KIND_KEY : KIND_VALUE;
                if (in_key_reg)
                begin
                    key_seen_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            high_reg     <= 4'd0;
            in_key_reg   <= 1'b1;
            key_seen_reg <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            high_reg     <= high_next;
            in_key_reg   <= in_key_next;
            key_seen_reg <= key_seen_next;
        end
    end

    a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        accept && opcode == OP_END |=> phase_reg == PH_IDLE && in_key_reg && !key_seen_reg)
        else $error("state not cleared after end of query");

    a_key_seen_only_in_key: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.kind == KIND_VALUE |-> !in_key_reg)
        else $error("value byte emitted while parsing key");

    a_marker_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.kind == KIND_END |-> res.out_byte == 8'd0)
        else $error("pair-end marker carries data");

endmodule

>>> rtl/uqpd_skid.sv
// ----------------------------------------------------------------------------
// uqpd_skid
// Output register with a skid stage, so the parser keeps taking bytes after
// the receiver stalls until one more result is held.
// ----------------------------------------------------------------------------
module uqpd_skid
    import uqpd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    space,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;

    assign space     = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_ready || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready || !out_valid_reg)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : push_data;
        end
        else if (push)
        begin
            skid_data_reg <= push_data;
        end
    end

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds data with empty output register");

    a_skid_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !out_ready && push))
        else $error("skid filled without a stall");

endmodule

>>> rtl/url_query_pair_decoder_unit.sv
// ----------------------------------------------------------------------------
// url_query_pair_decoder_unit
// Streaming percent-decoder for URL query strings with key/value tagging.
// ----------------------------------------------------------------------------
// Input: one transfer per query byte (s_tuser = 0, byte in s_tdata) or an
// end-of-query item (s_tuser = 1, s_tdata ignored).
// Output: one transfer per key byte, value byte or pair-end marker.
// m_tuser holds kind (0 key, 1 value, 2 pair end) and pair_kept; m_tlast
// marks the marker that closes the query. A '%' and the first escape digit
// produce no transfer; '=' switching to the value produces none either.
// Results are registered, in the output register or, while the receiver stalls,
// in the skid stage. Throughput: one input transfer per cycle while s_tready
// is high; the parser state updates on every accepted transfer.
// When the receiver stalls, one more result is held in a skid stage and
// s_tready drops until it drains. Reset clears the parser to the start of a
// key and empties both output stages.
// ----------------------------------------------------------------------------
module url_query_pair_decoder_unit
    import uqpd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tuser,   // [0] opcode
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [2:0] m_tuser,   // [1:0] kind, [2] pair_kept
    output logic       m_tlast    // query_done
);

    logic    accept;
    logic    res_valid;
    result_t res;
    result_t out_res;

    assign accept = s_tvalid && s_tready;

    uqpd_step u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .opcode    (s_tuser),
        .in_byte   (s_tdata),
        .res_valid (res_valid),
        .res       (res)
    );

    uqpd_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .space     (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = out_res.out_byte;
    assign m_tuser = {out_res.pair_kept, out_res.kind};
    assign m_tlast = out_res.query_done;

endmodule

>>> tb/query_token_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// query_token_checker
// Watches both stream channels of the query decoder. It tracks the parser
// state for every accepted input transfer, queues any decoded token that
// a transfer produces, and compares every output transfer field by field
// with the oldest queued token.
// ----------------------------------------------------------------------------
module query_token_checker
    import uqpd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tuser,   // [0] opcode
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,   // [7:0] out_byte
    input  logic [2:0] m_tuser,   // [1:0] kind, [2] pair_kept
    input  logic       m_tlast,   // query_done
    output int         errors,
    output int         outstanding
);

    result_t    decoded_tokens[$];
    phase_t     esc_phase;
    logic [3:0] hi_nibble;
    logic       in_key;
    logic       key_seen;

    function automatic logic [3:0] hex_value(input logic [7:0] digit);
        logic [4:0] idx;
        logic [3:0] nib;
        idx = digit[4:0];
        nib = 4'd0;
        if (idx >= 5'd1 && idx <= 5'd6)
            nib = 4'(idx + 5'd9);
        else if (idx >= 5'd17 && idx <= 5'd25)
            nib = 4'(idx - 5'd16);
        return nib;
    endfunction

    task automatic queue_token(input logic [7:0] b, input logic [1:0] k,
                               input logic kept, input logic done);
        result_t tok;
        tok.out_byte   = b;
        tok.kind       = k;
        tok.pair_kept  = kept;
        tok.query_done = done;
        decoded_tokens.insert(decoded_tokens.size(), tok);
    endtask

    task automatic queue_data(input logic [7:0] b);
        if (in_key)
        begin
            key_seen = 1'b1;
            queue_token(b, KIND_KEY, 1'b0, 1'b0);
        end
        else
        begin
            queue_token(b, KIND_VALUE, 1'b0, 1'b0);
        end
    endtask

    task automatic parse_query_byte(input logic op, input logic [7:0] b);
        if (op == OP_END)
        begin
            queue_token(8'h00, KIND_END, key_seen, 1'b1);
            esc_phase = PH_IDLE;
            hi_nibble = 4'd0;
            in_key    = 1'b1;
            key_seen  = 1'b0;
        end
        else if (esc_phase == PH_HIGH)
        begin
            hi_nibble = hex_value(b);
            esc_phase = PH_LOW;
        end
        else if (esc_phase == PH_LOW)
        begin
            esc_phase = PH_IDLE;
            queue_data({hi_nibble, hex_value(b)});
        end
        else
        begin
            esc_phase = PH_IDLE;
            if (b == CH_PERCENT)
            begin
                esc_phase = PH_HIGH;
            end
            else if (b == CH_AMP)
            begin
                queue_token(8'h00, KIND_END, key_seen, 1'b0);
                key_seen = 1'b0;
                in_key   = 1'b1;
            end
            else if (in_key && b == CH_EQUAL)
            begin
                in_key = 1'b0;
            end
            else
            begin
                queue_data(b);
            end
        end
    endtask

    task automatic compare_token();
        result_t want;
        if (decoded_tokens.size() == 0)
        begin
            $error("unexpected transfer: out_byte %0h kind %0d pair_kept %0b query_done %0b",
                   m_tdata, m_tuser[1:0], m_tuser[2], m_tlast);
            errors++;
        end
        else
        begin
            want = decoded_tokens.pop_front();
            if (m_tdata !== want.out_byte)
            begin
                $error("out_byte: expected %0h, got %0h", want.out_byte, m_tdata);
                errors++;
            end
            if (m_tuser[1:0] !== want.kind)
            begin
                $error("kind: expected %0d, got %0d", want.kind, m_tuser[1:0]);
                errors++;
            end
            if (m_tuser[2] !== want.pair_kept)
            begin
                $error("pair_kept: expected %0b, got %0b", want.pair_kept, m_tuser[2]);
                errors++;
            end
            if (m_tlast !== want.query_done)
            begin
                $error("query_done: expected %0b, got %0b", want.query_done, m_tlast);
                errors++;
            end
        end
    endtask

    // output side first, so a token queued at this edge is never matched here
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_phase = PH_IDLE;
            hi_nibble = 4'd0;
            in_key    = 1'b1;
            key_seen  = 1'b0;
            decoded_tokens.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
                compare_token();
            if (s_tvalid && s_tready)
                parse_query_byte(s_tuser, s_tdata);
        end
        outstanding = decoded_tokens.size();
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives query strings into the decoder: a directed opening covering escapes,
// separators, empty keys and unfinished escapes, then random queries mixed
// with noise, under random idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
module testbench;
    import uqpd_pkg::*;

    localparam int CYCLE_LIMIT  = 100000;
    localparam int HOLD_CYCLES  = 300;
    localparam int QUERY_BYTES  = 1875;
    localparam int DRAIN_CYCLES = 8;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] in_byte
    logic       s_tuser  = 1'b0;    // [0] opcode
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [7:0] out_byte
    logic [2:0] m_tuser;            // [1:0] kind, [2] pair_kept
    logic       m_tlast;

    int errors;
    int outstanding;
    int cycle_count = 0;
    int items_sent  = 0;
    int hold_req    = 0;
    bit quiet       = 1'b0;

    url_query_pair_decoder_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    query_token_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .errors      (errors),
        .outstanding (outstanding)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver: random back-pressure, plus one long hold counted here
    initial
    begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end
            else if (quiet)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(99) >= 17);
        end
    end

    task automatic offer_byte(input logic op, input logic [7:0] b);
        if (!quiet)
        begin
            while ($urandom_range(99) < 17)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic offer_text(input string s);
        for (int i = 0; i < s.len(); i++)
            offer_byte(OP_BYTE, s[i]);
    endtask

    function automatic logic [7:0] hex_char(input int n);
        logic [7:0] c;
        if (n < 10)
            c = 8'h30 + 8'(n);
        else if (n < 16)
            c = 8'h61 + 8'(n - 10);
        else
            c = 8'h41 + 8'(n - 16);
        return c;
    endfunction

    function automatic logic [7:0] plain_char();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (b == CH_PERCENT || b == CH_AMP || b == CH_EQUAL);
        return b;
    endfunction

    task automatic offer_digit();
        if ($urandom_range(99) < 85)
            offer_byte(OP_BYTE, hex_char($urandom_range(21)));
        else
            offer_byte(OP_BYTE, 8'($urandom_range(255)));
    endtask

    task automatic offer_token();
        int r;
        r = $urandom_range(99);
        if (r < 65)
            offer_byte(OP_BYTE, plain_char());
        else if (r < 88)
        begin
            offer_byte(OP_BYTE, CH_PERCENT);
            offer_digit();
            offer_digit();
        end
        else if (r < 94)
            offer_byte(OP_BYTE, CH_EQUAL);
        else
            offer_byte(OP_BYTE, 8'($urandom_range(255)));
    endtask

    task automatic offer_query();
        int npairs;
        int nk;
        int nv;
        npairs = $urandom_range(4);
        for (int p = 0; p < npairs; p++)
        begin
            if (p > 0)
                offer_byte(OP_BYTE, CH_AMP);
            nk = $urandom_range(5);
            for (int k = 0; k < nk; k++)
                offer_token();
            if ($urandom_range(99) < 80)
            begin
                offer_byte(OP_BYTE, CH_EQUAL);
                nv = $urandom_range(5);
                for (int v = 0; v < nv; v++)
                    offer_token();
            end
        end
        if ($urandom_range(9) < 9)
            offer_byte(OP_END, 8'($urandom_range(255)));
    endtask

    task automatic offer_noise();
        int n;
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++)
            offer_byte(($urandom_range(15) == 0) ? OP_END : OP_BYTE,
                       8'($urandom_range(255)));
    endtask

    initial
    begin
        bit hold_done;
        hold_done = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // empty query, escapes in key and value, escaped separators,
        // separators as escape digits, empty-key pair, unfinished escapes
        offer_byte(OP_END, 8'hFF);
        offer_text("k%41%3D==%fF%%&&");
        offer_text("=v&");
        offer_byte(OP_BYTE, 8'h00);
        offer_byte(OP_BYTE, 8'hFF);
        offer_text("%g0");
        offer_text("%z");
        offer_byte(OP_END, 8'h00);

        while (items_sent < QUERY_BYTES)
        begin
            quiet = (items_sent >= 600 && items_sent < 900);
            if (items_sent >= 650 && !hold_done)
            begin
                hold_req++;
                hold_done = 1'b1;
            end
            if ($urandom_range(99) < 12)
                offer_noise();
            else
                offer_query();
        end
        offer_byte(OP_END, 8'h00);
        quiet = 1'b0;
        s_tvalid <= 1'b0;

        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> sim.f
rtl/uqpd_pkg.sv
rtl/uqpd_step.sv
rtl/uqpd_skid.sv
rtl/url_query_pair_decoder_unit.sv
tb/query_token_checker.sv
tb/testbench.sv
